// ===== rtl/core/wavhd_pkg.sv =====
// Shared types and constants of the WAV header deframer.
`timescale 1ns / 1ps

package wavhd_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RIFF     = 3'd1,
    ERR_WAVE     = 3'd2,
    ERR_FMT      = 3'd3,
    ERR_CHANNELS = 3'd4,
    ERR_DATA     = 3'd5
  } err_t;

  // Tags as they sit in the shift register after four little-endian bytes.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] MONO_CHANNELS = 16'd1;

  // Header positions of the last byte of each field that is checked or kept.
  localparam logic [5:0] POS_RIFF     = 6'd3;
  localparam logic [5:0] POS_WAVE     = 6'd11;
  localparam logic [5:0] POS_FMT      = 6'd15;
  localparam logic [5:0] POS_CHANNELS = 6'd23;
  localparam logic [5:0] POS_RATE     = 6'd27;
  localparam logic [5:0] POS_BITS     = 6'd35;
  localparam logic [5:0] POS_DATA     = 6'd39;
  localparam logic [5:0] POS_SIZE     = 6'd43;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sample;
    logic        last;
    err_t        err;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] size;
  } result_t;

endpackage

// ===== rtl/core/wavhd_parse.sv =====
// Input register and header parser of the WAV header deframer.
`timescale 1ns / 1ps

module wavhd_parse import wavhd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] file_byte,
  input  logic       first_of_file,
  output logic       byte_stall,
  input  logic       res_ready,
  output logic       res_load,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_IDLE   = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  logic        in_full;
  logic [7:0]  in_byte;
  logic        in_first;

  phase_t      phase, phase_next;
  logic [5:0]  header_position, header_position_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] rate_store, rate_store_next;
  logic [15:0] bits_store, bits_store_next;
  logic [31:0] remaining_bytes, remaining_bytes_next;

  phase_t      phase_eff;
  logic [5:0]  pos;
  logic [31:0] shifted;
  logic [31:0] rem_dec;
  logic        emit;
  logic        advance;

  assign advance    = in_full && res_ready;
  assign byte_stall = in_full && !res_ready;
  assign res_load   = advance && emit;

  always_comb begin
    phase_eff = in_first ? PH_HEADER : phase;
    pos       = in_first ? 6'd0 : header_position;
    shifted   = {in_byte, field_shift[31:8]};
    rem_dec   = remaining_bytes - 32'd1;

    phase_next           = phase_eff;
    header_position_next = pos;
    field_shift_next     = field_shift;
    rate_store_next      = rate_store;
    bits_store_next      = bits_store;
    remaining_bytes_next = remaining_bytes;

    emit = 1'b0;
    res  = '{kind: KIND_SAMPLE, sample: 8'd0, last: 1'b0, err: ERR_NONE,
             rate: 32'd0, bits: 16'd0, size: 32'd0};

    case (phase_eff)
      PH_DATA: begin
        remaining_bytes_next = rem_dec;
        emit       = 1'b1;
        res.sample = in_byte;
        if (rem_dec == 32'd0) begin
          res.last   = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      PH_HEADER: begin
        field_shift_next     = shifted;
        header_position_next = pos + 6'd1;
        case (pos)
          POS_RIFF: begin
            if (shifted != TAG_RIFF) begin
              emit = 1'b1;
              res.kind = KIND_ERROR;
              res.err  = ERR_RIFF;
            end
          end
          POS_WAVE: begin
            if (shifted != TAG_WAVE) begin
              emit = 1'b1;
              res.kind = KIND_ERROR;
              res.err  = ERR_WAVE;
            end
          end
          POS_FMT: begin
            if (shifted != TAG_FMT) begin
              emit = 1'b1;
              res.kind = KIND_ERROR;
              res.err  = ERR_FMT;
            end
          end
          POS_CHANNELS: begin
            if (shifted[31:16] != MONO_CHANNELS) begin
              emit = 1'b1;
              res.kind = KIND_ERROR;
              res.err  = ERR_CHANNELS;
            end
          end
          POS_RATE: begin
            rate_store_next = shifted;
          end
          POS_BITS: begin
            bits_store_next = shifted[31:16];
          end
          POS_DATA: begin
            if (shifted != TAG_DATA) begin
              emit = 1'b1;
              res.kind = KIND_ERROR;
              res.err  = ERR_DATA;
            end
          end
          POS_SIZE: begin
            emit = 1'b1;
            remaining_bytes_next = shifted;
            phase_next = (shifted == 32'd0) ? PH_IDLE : PH_DATA;
            res.kind = KIND_HEADER;
            res.rate = rate_store;
            res.bits = bits_store;
            res.size = shifted;
          end
          default: begin
          end
        endcase
        // Every failed check parks the parser until the next file starts.
        if (res.kind == KIND_ERROR) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full         <= 1'b0;
      phase           <= PH_HEADER;
      header_position <= 6'd0;
      field_shift     <= 32'd0;
      rate_store      <= 32'd0;
      bits_store      <= 16'd0;
      remaining_bytes <= 32'd0;
    end else begin
      if (byte_valid && !byte_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        phase           <= phase_next;
        header_position <= header_position_next;
        field_shift     <= field_shift_next;
        rate_store      <= rate_store_next;
        bits_store      <= bits_store_next;
        remaining_bytes <= remaining_bytes_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte  <= file_byte;
      in_first <= first_of_file;
    end
  end

endmodule

// ===== rtl/core/wavhd_out.sv =====
// Result register of the WAV header deframer.
`timescale 1ns / 1ps

module wavhd_out import wavhd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_load,
  input  result_t     res,
  output logic        res_ready,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  sample_value,
  output logic        last_sample,
  output logic [2:0]  error_code,
  output logic [31:0] rate_hz,
  output logic [15:0] sample_bits,
  output logic [31:0] data_bytes
);

  result_t held;

  assign res_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_load) begin
      held <= res;
    end
  end

  assign result_kind  = held.kind;
  assign sample_value = held.sample;
  assign last_sample  = held.last;
  assign error_code   = held.err;
  assign rate_hz      = held.rate;
  assign sample_bits  = held.bits;
  assign data_bytes   = held.size;

endmodule

// ===== rtl/core/wav_header_deframer.sv =====
// Top level of the WAV header deframer: byte stream in, header, samples and errors out.
//
//   channel   direction  handshake                     payload
//   byte      in         byte_valid / byte_stall       file_byte, first_of_file
//   result    out        result_valid / result_stall   result_kind, sample_value,
//                                                      last_sample, error_code,
//                                                      rate_hz, sample_bits,
//                                                      data_bytes
//
// One byte is taken every cycle while byte_stall is low; a beat passes through
// an input register and the parser into the result register.
// Header and data bytes are handled by the same single pass of parse logic.
// Reset is synchronous and puts the parser into header phase at byte zero.
// A stall on the result side holds the result register and then the input
// register, which raises byte_stall; every byte waits for room in the result
// register, even one that gives no result.
`timescale 1ns / 1ps

module wav_header_deframer import wavhd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  file_byte,
  input  logic        first_of_file,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  sample_value,
  output logic        last_sample,
  output logic [2:0]  error_code,
  output logic [31:0] rate_hz,
  output logic [15:0] sample_bits,
  output logic [31:0] data_bytes
);

  logic    res_ready;
  logic    res_load;
  result_t res;

  wavhd_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .file_byte     (file_byte),
    .first_of_file (first_of_file),
    .byte_stall    (byte_stall),
    .res_ready     (res_ready),
    .res_load      (res_load),
    .res           (res)
  );

  wavhd_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res          (res),
    .res_ready    (res_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .error_code   (error_code),
    .rate_hz      (rate_hz),
    .sample_bits  (sample_bits),
    .data_bytes   (data_bytes)
  );

endmodule
